FILE: rtl/core/fpa_pkg.sv
package fpa_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [3:0] FN_ADD  = 4'd0;
    localparam logic [3:0] FN_SUB  = 4'd1;
    localparam logic [3:0] FN_MUL  = 4'd2;
    localparam logic [3:0] FN_DIV  = 4'd3;
    localparam logic [3:0] FN_GT   = 4'd4;
    localparam logic [3:0] FN_LT   = 4'd5;
    localparam logic [3:0] FN_GE   = 4'd6;
    localparam logic [3:0] FN_LE   = 4'd7;
    localparam logic [3:0] FN_EQ   = 4'd8;
    localparam logic [3:0] FN_NE   = 4'd9;
    localparam logic [3:0] FN_MIN  = 4'd10;
    localparam logic [3:0] FN_MAX  = 4'd11;
    localparam logic [3:0] FN_INC  = 4'd12;
    localparam logic [3:0] FN_DEC  = 4'd13;
    localparam logic [3:0] FN_FINT = 4'd14;
    localparam logic [3:0] FN_TINT = 4'd15;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result;
        logic               cmp_true;
        logic               overflow;
        logic               div_zero;
    } t_out;

endpackage

FILE: rtl/core/fixed_point_q24_8_alu_unit.sv
// Fixed-point ALU, signed WORD_BITS words with FRAC_BITS fraction bits.
// The output timing is set by the restoring divider, one quotient bit a stage;
// the word is taken at the edge that ends the cycle in which the strobe is high.
// Throughput: one word per cycle for every operation; busy stays low, and the
// receiver cannot stall, so results leave on o_done without backpressure.
// Reset (synchronous, active low) clears the valid bits; data is not reset.
module fixed_point_q24_8_alu_unit #(
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  fpa_pkg::t_in  i_in,
    output logic          busy,
    output logic          o_done,
    output fpa_pkg::t_out o_out
);

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int NB   = W + F;
    localparam int H    = (W + 1) / 2;
    localparam int L    = W - H;
    localparam int LAST = NB + 2;
    localparam int MULS = 3;

    localparam logic [W-1:0] SBIT = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [2*W:0] HALF = (F > 0) ? ((2*W+1)'(1) << (F - 1)) : '0;

    typedef struct packed {
        logic [W-1:0] res;
        logic         cmp;
        logic         ovf;
        logic         dz;
        logic         is_div;
        logic         is_mul;
        logic         neg;
    } t_side;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // ---------------- stage 0: decode and simple operations
    logic signed [W-1:0] aw, bw, sum_ab, dif_ab, top_a;
    logic [W-1:0]        ma, mb;
    t_side               n_sd;

    assign aw     = W'(i_in.a);
    assign bw     = W'(i_in.b);
    assign ma     = aw[W-1] ? (W'(0) - aw) : aw;
    assign mb     = bw[W-1] ? (W'(0) - bw) : bw;
    assign sum_ab = aw + bw;
    assign dif_ab = aw - bw;
    assign top_a  = aw >>> (W - 1 - F);

    always_comb begin
        n_sd        = '0;
        n_sd.neg    = aw[W-1] ^ bw[W-1];
        unique case (i_in.func)
            fpa_pkg::FN_ADD: begin
                n_sd.res = sum_ab;
                if (aw[W-1] == bw[W-1] && sum_ab[W-1] != aw[W-1]) begin
                    n_sd.ovf = 1'b1;
                    n_sd.res = aw[W-1] ? SBIT : MAXP;
                end
            end
            fpa_pkg::FN_SUB: begin
                n_sd.res = dif_ab;
                if (aw[W-1] != bw[W-1] && dif_ab[W-1] != aw[W-1]) begin
                    n_sd.ovf = 1'b1;
                    n_sd.res = aw[W-1] ? SBIT : MAXP;
                end
            end
            fpa_pkg::FN_MUL: n_sd.is_mul = 1'b1;
            fpa_pkg::FN_DIV: begin
                n_sd.is_div = 1'b1;
                if (bw == '0) begin
                    n_sd.dz  = 1'b1;
                    n_sd.res = aw[W-1] ? SBIT : MAXP;
                end
            end
            fpa_pkg::FN_GT:  n_sd.cmp = aw > bw;
            fpa_pkg::FN_LT:  n_sd.cmp = aw < bw;
            fpa_pkg::FN_GE:  n_sd.cmp = aw >= bw;
            fpa_pkg::FN_LE:  n_sd.cmp = aw <= bw;
            fpa_pkg::FN_EQ:  n_sd.cmp = aw == bw;
            fpa_pkg::FN_NE:  n_sd.cmp = aw != bw;
            fpa_pkg::FN_MIN: n_sd.res = (aw < bw) ? aw : bw;
            fpa_pkg::FN_MAX: n_sd.res = (aw > bw) ? aw : bw;
            fpa_pkg::FN_INC: begin
                n_sd.ovf = (aw == MAXP);
                n_sd.res = (aw == MAXP) ? MAXP : W'(aw + W'(1));
            end
            fpa_pkg::FN_DEC: begin
                n_sd.ovf = (aw == SBIT);
                n_sd.res = (aw == SBIT) ? SBIT : W'(aw - W'(1));
            end
            fpa_pkg::FN_FINT: begin
                // fits when the top F+1 bits all match the sign
                if (top_a == '0 || top_a == '1) begin
                    n_sd.res = aw <<< F;
                end else begin
                    n_sd.ovf = 1'b1;
                    n_sd.res = aw[W-1] ? SBIT : MAXP;
                end
            end
            fpa_pkg::FN_TINT: n_sd.res = aw >>> F;
            default:          n_sd.res = '0;
        endcase
    end

    logic  r_v  [0:LAST];
    t_side r_sd [0:LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= accept;
        end
        r_sd[0] <= n_sd;
    end

    // ---------------- multiplier: partial products, sum, round and saturate
    logic [W-1:0]     r_ma, r_mb;
    logic [2*H-1:0]   r_pll;
    logic [H+L-1:0]   r_plh, r_phl;
    logic [2*L-1:0]   r_phh;
    logic [2*W-1:0]   r_prod;
    logic [2*W:0]     pr, pv;
    logic [W-1:0]     mul_res;
    logic             mul_ovf;
    t_side            mul_sd;

    always_ff @(posedge i_clk) begin
        r_ma   <= ma;
        r_mb   <= mb;
        r_pll  <= r_ma[H-1:0] * r_mb[H-1:0];
        r_plh  <= r_ma[H-1:0] * r_mb[W-1:H];
        r_phl  <= r_ma[W-1:H] * r_mb[H-1:0];
        r_phh  <= r_ma[W-1:H] * r_mb[W-1:H];
        r_prod <= (2*W)'(r_pll)
                + (((2*W)'(r_plh) + (2*W)'(r_phl)) << H)
                + ((2*W)'(r_phh) << (2*H));
    end

    assign pr = {1'b0, r_prod} + HALF;
    assign pv = pr >> F;

    always_comb begin
        mul_ovf = 1'b0;
        mul_res = W'(pv);
        if (r_sd[MULS-1].neg) begin
            if (pv > (2*W+1)'(SBIT)) begin
                mul_ovf = 1'b1;
                mul_res = SBIT;
            end else begin
                mul_res = W'(0) - W'(pv);
            end
        end else if (pv > (2*W+1)'(MAXP)) begin
            mul_ovf = 1'b1;
            mul_res = MAXP;
        end
    end

    always_comb begin
        mul_sd = r_sd[MULS-1];
        if (mul_sd.is_mul) begin
            mul_sd.res = mul_res;
            mul_sd.ovf = mul_ovf;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage
    logic [W-1:0]  r_dr [0:NB];
    logic [W-1:0]  r_dd [0:NB];
    logic [NB-1:0] r_dq [0:NB];
    logic [NB-1:0] r_dn [0:NB];

    always_ff @(posedge i_clk) begin
        r_dr[0] <= '0;
        r_dq[0] <= '0;
        r_dn[0] <= NB'(ma) << F;
        r_dd[0] <= mb;
    end

    for (genvar s = 0; s < NB; s++) begin : g_div
        logic [W:0] rs, rd;
        logic       ge;
        assign rs = {r_dr[s], r_dn[s][NB-1]};
        assign ge = rs >= {1'b0, r_dd[s]};
        assign rd = rs - {1'b0, r_dd[s]};
        always_ff @(posedge i_clk) begin
            r_dr[s+1] <= ge ? rd[W-1:0] : rs[W-1:0];
            r_dq[s+1] <= {r_dq[s][NB-2:0], ge};
            r_dn[s+1] <= r_dn[s] << 1;
            r_dd[s+1] <= r_dd[s];
        end
    end

    // round half away: bump when remainder is at least half the divisor
    logic [NB:0] r_qr;
    always_ff @(posedge i_clk) begin
        r_qr <= {1'b0, r_dq[NB]}
              + (NB+1)'({r_dr[NB], 1'b0} >= {1'b0, r_dd[NB]});
    end

    t_side div_sd;
    always_comb begin
        div_sd = r_sd[LAST-1];
        if (div_sd.is_div && !div_sd.dz) begin
            if (div_sd.neg) begin
                if (r_qr > (NB+1)'(SBIT)) begin
                    div_sd.ovf = 1'b1;
                    div_sd.res = SBIT;
                end else begin
                    div_sd.res = W'(0) - r_qr[W-1:0];
                end
            end else if (r_qr > (NB+1)'(MAXP)) begin
                div_sd.ovf = 1'b1;
                div_sd.res = MAXP;
            end else begin
                div_sd.res = r_qr[W-1:0];
            end
        end
    end

    // ---------------- side-band pipeline carrying valid and early results
    for (genvar s = 0; s < LAST; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
        end
        if (s + 1 == MULS) begin : g_mul
            always_ff @(posedge i_clk) begin
                r_sd[s+1] <= mul_sd;
            end
        end else if (s + 1 == LAST) begin : g_fin
            always_ff @(posedge i_clk) begin
                r_sd[s+1] <= div_sd;
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                r_sd[s+1] <= r_sd[s];
            end
        end
    end

    logic signed [W-1:0] res_s;
    assign res_s          = r_sd[LAST].res;
    assign o_done         = r_v[LAST];
    assign o_out.result   = 32'(res_s);
    assign o_out.cmp_true = r_sd[LAST].cmp;
    assign o_out.overflow = r_sd[LAST].ovf;
    assign o_out.div_zero = r_sd[LAST].dz;

    // ---------------- assertions
    logic signed [W-1:0] lim_p, lim_n;
    assign lim_p = MAXP;
    assign lim_n = SBIT;

    a_done_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAST + 1))
        else $error("strobe without matching accepted word");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.cmp_true) |-> (!o_out.overflow && !o_out.div_zero
                                       && o_out.result == '0))
        else $error("compare word carries result or flags");

    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.div_zero) |-> !o_out.overflow)
        else $error("divide by zero also flagged overflow");

    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_out.overflow || o_out.div_zero)) |->
            (o_out.result == 32'(lim_p) || o_out.result == 32'(lim_n)))
        else $error("saturated word is not a limit");

endmodule

FILE: bench/tb_fixed_point_q24_8_alu_unit.sv
`timescale 1ns / 1ps

module tb_fixed_point_q24_8_alu_unit;

    localparam int LATENCY = fpa_pkg::WORD_BITS_DEF + fpa_pkg::FRAC_BITS_DEF + 3;
    localparam logic signed [31:0] MAX_POS = 32'sh7fffffff;
    localparam logic signed [31:0] MAX_NEG = 32'sh80000000;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    fpa_pkg::t_in   i_in;
    logic           busy;
    logic           o_done;
    fpa_pkg::t_out  o_out;

    fpa_pkg::t_out  expected_q[$];
    int             n_errors;

    fixed_point_q24_8_alu_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_in    (i_in),
        .busy    (busy),
        .o_done  (o_done),
        .o_out   (o_out)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #1ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Saturate a wide signed value into the 32-bit word.
    function automatic fpa_pkg::t_out sat_word(input logic signed [127:0] v);
        fpa_pkg::t_out r;
        r = '0;
        if (v > 128'sd2147483647) begin
            r.result = MAX_POS;
            r.overflow = 1'b1;
        end else if (v < -128'sd2147483648) begin
            r.result = MAX_NEG;
            r.overflow = 1'b1;
        end else begin
            r.result = v[31:0];
        end
        return r;
    endfunction

    function automatic fpa_pkg::t_out alu_predict(input fpa_pkg::t_in w);
        fpa_pkg::t_out r;
        logic signed [127:0] sa, sb, prod;
        logic [127:0] ma, mb, mq, mr;
        logic neg;
        r = '0;
        sa = 128'(w.a);
        sb = 128'(w.b);
        case (w.func)
            fpa_pkg::FN_ADD: r = sat_word(sa + sb);
            fpa_pkg::FN_SUB: r = sat_word(sa - sb);
            fpa_pkg::FN_MUL: begin
                prod = sa * sb;
                neg = prod < 0;
                ma = neg ? -prod : prod;
                mq = (ma + 128'd128) >> fpa_pkg::FRAC_BITS_DEF;
                r = sat_word(neg ? -$signed(mq) : $signed(mq));
            end
            fpa_pkg::FN_DIV: begin
                if (w.b == 0) begin
                    r.result = w.a < 0 ? MAX_NEG : MAX_POS;
                    r.div_zero = 1'b1;
                end else begin
                    neg = (sa < 0) != (sb < 0);
                    ma = sa < 0 ? -sa : sa;
                    mb = sb < 0 ? -sb : sb;
                    ma = ma << fpa_pkg::FRAC_BITS_DEF;
                    mq = ma / mb;
                    mr = ma % mb;
                    if (2 * mr >= mb) mq = mq + 1;
                    r = sat_word(neg ? -$signed(mq) : $signed(mq));
                end
            end
            fpa_pkg::FN_GT: r.cmp_true = w.a > w.b;
            fpa_pkg::FN_LT: r.cmp_true = w.a < w.b;
            fpa_pkg::FN_GE: r.cmp_true = w.a >= w.b;
            fpa_pkg::FN_LE: r.cmp_true = w.a <= w.b;
            fpa_pkg::FN_EQ: r.cmp_true = w.a == w.b;
            fpa_pkg::FN_NE: r.cmp_true = w.a != w.b;
            fpa_pkg::FN_MIN: r.result = w.a < w.b ? w.a : w.b;
            fpa_pkg::FN_MAX: r.result = w.a > w.b ? w.a : w.b;
            fpa_pkg::FN_INC: r = sat_word(sa + 1);
            fpa_pkg::FN_DEC: r = sat_word(sa - 1);
            fpa_pkg::FN_FINT: r = sat_word(sa <<< fpa_pkg::FRAC_BITS_DEF);
            default: r.result = w.a >>> fpa_pkg::FRAC_BITS_DEF;
        endcase
        return r;
    endfunction

    // Result checker; samples on the edge, so results never race the driver.
    always @(posedge i_clk) begin
        fpa_pkg::t_out e;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                $error("unexpected word: result %0d", o_out.result);
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_out.result !== e.result) begin
                    $error("result: expected %0d actual %0d", e.result, o_out.result);
                    n_errors++;
                end
                if (o_out.cmp_true !== e.cmp_true) begin
                    $error("cmp_true: expected %0b actual %0b", e.cmp_true, o_out.cmp_true);
                    n_errors++;
                end
                if (o_out.overflow !== e.overflow) begin
                    $error("overflow: expected %0b actual %0b", e.overflow, o_out.overflow);
                    n_errors++;
                end
                if (o_out.div_zero !== e.div_zero) begin
                    $error("div_zero: expected %0b actual %0b", e.div_zero, o_out.div_zero);
                    n_errors++;
                end
            end
        end
    end

    typedef struct {
        fpa_pkg::t_in  word;
        int            has_exp;
        fpa_pkg::t_out exp;
    } t_vec;

    int idle_pct;

    // Present one word; start stays high across back-to-back words.
    task automatic send_word(input fpa_pkg::t_in w, input fpa_pkg::t_out e);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_q.push_back(e);
    endtask

    function automatic fpa_pkg::t_in rnd_word();
        fpa_pkg::t_in w;
        w.func = 4'($urandom_range(15));
        w.a = $urandom;
        w.b = $urandom;
        case ($urandom_range(7))
            0: w.a = 32'($signed(17'($urandom)));
            1: w.b = 32'($signed(12'($urandom)));
            2: w.b = '0;
            3: begin
                w.a = 32'($signed(20'($urandom)));
                w.b = 32'($signed(20'($urandom)));
            end
            4: w.a = $urandom_range(3) == 0 ? MAX_POS : MAX_NEG;
            5: w.b = w.a;
            default: ;
        endcase
        return w;
    endfunction

    function automatic fpa_pkg::t_out mk(input logic signed [31:0] r, input int c,
                                         input int o, input int d);
        fpa_pkg::t_out e;
        e.result = r;
        e.cmp_true = c[0];
        e.overflow = o[0];
        e.div_zero = d[0];
        return e;
    endfunction

    initial begin
        t_vec          dir_tbl[$];
        fpa_pkg::t_in  w;
        int            waited;
        n_errors = 0;
        idle_pct = 0;
        start    = 1'b0;
        i_in     = '0;
        i_rst_n  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_tbl = '{
            '{'{fpa_pkg::FN_ADD, MAX_POS, 32'sd1}, 1, mk(MAX_POS, 0, 1, 0)},
            '{'{fpa_pkg::FN_ADD, MAX_NEG, -32'sd1}, 1, mk(MAX_NEG, 0, 1, 0)},
            '{'{fpa_pkg::FN_SUB, MAX_NEG, 32'sd1}, 1, mk(MAX_NEG, 0, 1, 0)},
            '{'{fpa_pkg::FN_SUB, 32'sd0, MAX_NEG}, 1, mk(MAX_POS, 0, 1, 0)},
            '{'{fpa_pkg::FN_MUL, MAX_POS, MAX_POS}, 1, mk(MAX_POS, 0, 1, 0)},
            '{'{fpa_pkg::FN_MUL, MAX_NEG, MAX_POS}, 1, mk(MAX_NEG, 0, 1, 0)},
            '{'{fpa_pkg::FN_MUL, 32'sd384, -32'sd128}, 0, '0},
            '{'{fpa_pkg::FN_MUL, -32'sd1, 32'sd128}, 0, '0},
            '{'{fpa_pkg::FN_DIV, 32'sd5, 32'sd0}, 1, mk(MAX_POS, 0, 0, 1)},
            '{'{fpa_pkg::FN_DIV, -32'sd5, 32'sd0}, 1, mk(MAX_NEG, 0, 0, 1)},
            '{'{fpa_pkg::FN_DIV, 32'sd0, 32'sd0}, 1, mk(MAX_POS, 0, 0, 1)},
            '{'{fpa_pkg::FN_DIV, MAX_NEG, 32'sd1}, 1, mk(MAX_NEG, 0, 1, 0)},
            '{'{fpa_pkg::FN_DIV, 32'sd1, -32'sd512}, 0, '0},
            '{'{fpa_pkg::FN_GT, MAX_POS, MAX_NEG}, 1, mk(0, 1, 0, 0)},
            '{'{fpa_pkg::FN_LT, MAX_POS, MAX_NEG}, 1, mk(0, 0, 0, 0)},
            '{'{fpa_pkg::FN_GE, 32'sd7, 32'sd7}, 1, mk(0, 1, 0, 0)},
            '{'{fpa_pkg::FN_LE, 32'sd8, 32'sd7}, 1, mk(0, 0, 0, 0)},
            '{'{fpa_pkg::FN_EQ, MAX_NEG, MAX_NEG}, 1, mk(0, 1, 0, 0)},
            '{'{fpa_pkg::FN_NE, MAX_NEG, MAX_NEG}, 1, mk(0, 0, 0, 0)},
            '{'{fpa_pkg::FN_MIN, MAX_POS, MAX_NEG}, 1, mk(MAX_NEG, 0, 0, 0)},
            '{'{fpa_pkg::FN_MAX, MAX_POS, MAX_NEG}, 1, mk(MAX_POS, 0, 0, 0)},
            '{'{fpa_pkg::FN_INC, MAX_POS, 32'sd3}, 1, mk(MAX_POS, 0, 1, 0)},
            '{'{fpa_pkg::FN_DEC, MAX_NEG, 32'sd3}, 1, mk(MAX_NEG, 0, 1, 0)},
            '{'{fpa_pkg::FN_FINT, 32'sh00800000, 32'sd0}, 1, mk(MAX_POS, 0, 1, 0)},
            '{'{fpa_pkg::FN_FINT, 32'shff800000, -32'sd1}, 1, mk(MAX_NEG, 0, 0, 0)},
            '{'{fpa_pkg::FN_TINT, MAX_NEG, -32'sd1}, 1, mk(32'shff800000, 0, 0, 0)}
        };
        foreach (dir_tbl[i]) begin
            send_word(dir_tbl[i].word,
                      dir_tbl[i].has_exp != 0 ? dir_tbl[i].exp
                                              : alu_predict(dir_tbl[i].word));
        end

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = ph == 0 ? 0 : ph == 1 ? 49 : ph == 2 ? 0 : 29;
            for (int k = 0; k < 385; k++) begin
                w = rnd_word();
                send_word(w, alu_predict(w));
            end
            if (ph == 1) begin
                // drain the pipe before the next phase
                start <= 1'b0;
                while (expected_q.size() != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        waited = 0;
        while (expected_q.size() != 0 && waited < 20 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 5) @(posedge i_clk);

        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (expected_q.size() != 0) $error("%0d words never arrived", expected_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/fpa_pkg.sv
rtl/core/fixed_point_q24_8_alu_unit.sv
bench/tb_fixed_point_q24_8_alu_unit.sv
